// ===== src/xcr_pkg.sv =====
// Package for the XMODEM-CRC receiver: protocol bytes, phase and event codes,
// result and queue-entry types, and the CRC-16 byte update.
// No dependencies.
`timescale 1ns / 1ps

package xcr_pkg;

  localparam int PAYLOAD_BYTES_DEF = 128;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_REQ = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [7:0]  BLOCK_SUM = 8'd255;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_STOP  = 2'd3;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_ACCEPT = 3'd1;
  localparam logic [2:0] EV_REJECT = 3'd2;
  localparam logic [2:0] EV_DONE   = 3'd3;
  localparam logic [2:0] EV_ABORT  = 3'd4;

  localparam logic [1:0] REG_INIT_RETRY   = 2'd0;
  localparam logic [1:0] REG_INIT_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_ACK_PERIOD   = 2'd2;
  localparam logic [1:0] REG_PKT_TIMEOUT  = 2'd3;

  localparam logic [15:0] INIT_RETRY_RST   = 16'd1000;
  localparam logic [15:0] INIT_TIMEOUT_RST = 16'd30000;
  localparam logic [15:0] ACK_PERIOD_RST   = 16'd20;
  localparam logic [15:0] PKT_TIMEOUT_RST  = 16'd1000;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_INIT     = 3'd1,
    PH_RECV     = 3'd2,
    PH_WAIT     = 3'd3,
    PH_CAN_INIT = 3'd4,
    PH_CAN_WAIT = 3'd5
  } phase_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic [2:0] event_res;
  } res_t;

  // An entry with cancel_first set is delivered as two beats: a CAN first,
  // then the stored result.
  typedef struct packed {
    logic cancel_first;
    res_t res;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } qwr_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/xcr_if.sv =====
// Valid/ready channel interfaces for the receiver's input items and results.
// Depends on nothing but the port widths of the result fields.
`timescale 1ns / 1ps

interface xcr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

interface xcr_result_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [6:0] data_index;
  logic [2:0] event_res;
  logic       last;

  modport source (output valid, tx_valid, tx_byte, data_valid, data_byte,
                  data_index, event_res, last, input ready);
  modport sink (input valid, tx_valid, tx_byte, data_valid, data_byte,
                data_index, event_res, last, output ready);
endinterface

// ===== src/xcr_ctrl.sv =====
// Protocol controller: configuration registers, phase machine, frame
// counters, running CRC and timers. Produces at most one queue entry per item.
// Depends on xcr_pkg.
`timescale 1ns / 1ps

module xcr_ctrl #(
  parameter int PAYLOAD_BYTES = xcr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [1:0]   action,
  input  logic [7:0]   rx_byte,
  input  logic         wr_en,
  input  logic [1:0]   wr_index,
  input  logic [15:0]  wr_data,
  output xcr_pkg::qwr_t qwr,
  output logic         idle
);
  import xcr_pkg::*;

  localparam int CW = $clog2(PAYLOAD_BYTES + 4);
  localparam int IW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] N_HDR = CW'(2);
  localparam logic [CW-1:0] N_CRC_HI = CW'(PAYLOAD_BYTES + 2);

  logic [15:0] init_retry_period;
  logic [15:0] init_timeout;
  logic [15:0] ack_repeat_period;
  logic [15:0] packet_timeout;

  phase_t      phase, phase_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]  block_number, block_number_next;
  logic        header_ok, header_ok_next;
  logic [15:0] crc_running, crc_running_next;
  logic [7:0]  crc_high_received, crc_high_received_next;
  logic        frame_good, frame_good_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic [15:0] period_ticks, period_ticks_next;

  logic [15:0] elapsed_inc, limit, period_sel, period_inc;
  logic        timed_out, repeats, period_hit, frame_ok;
  logic [15:0] crc_new;
  logic [IW-1:0] data_pos;

  assign idle = (phase == PH_IDLE);
  assign elapsed_inc = (elapsed_ticks == 16'hFFFF) ? elapsed_ticks : elapsed_ticks + 16'd1;
  assign limit = (phase == PH_INIT || phase == PH_CAN_INIT) ? init_timeout : packet_timeout;
  assign timed_out = (elapsed_inc >= limit);
  assign repeats = (phase == PH_INIT || phase == PH_WAIT);
  assign period_sel = (phase == PH_INIT) ? init_retry_period : ack_repeat_period;
  assign period_inc = period_ticks + 16'd1;
  assign period_hit = (period_inc >= period_sel);
  assign crc_new = crc_byte(crc_running, rx_byte);
  assign frame_ok = header_ok && ({crc_high_received, rx_byte} == crc_running);
  assign data_pos = IW'(byte_count) - IW'(N_HDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      init_retry_period <= INIT_RETRY_RST;
      init_timeout <= INIT_TIMEOUT_RST;
      ack_repeat_period <= ACK_PERIOD_RST;
      packet_timeout <= PKT_TIMEOUT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_INIT_RETRY: init_retry_period <= wr_data;
        REG_INIT_TIMEOUT: init_timeout <= wr_data;
        REG_ACK_PERIOD: ack_repeat_period <= wr_data;
        REG_PKT_TIMEOUT: packet_timeout <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    block_number_next = block_number;
    header_ok_next = header_ok;
    crc_running_next = crc_running;
    crc_high_received_next = crc_high_received;
    frame_good_next = frame_good;
    elapsed_ticks_next = elapsed_ticks;
    period_ticks_next = period_ticks;
    case (action)
      ACT_START: begin
        if (phase == PH_IDLE) begin
          byte_count_next = '0;
          block_number_next = '0;
          header_ok_next = 1'b0;
          crc_running_next = CRC_INIT;
          crc_high_received_next = '0;
          frame_good_next = 1'b0;
          elapsed_ticks_next = '0;
          period_ticks_next = '0;
          phase_next = PH_INIT;
        end
      end
      ACT_STOP: begin
        phase_next = PH_IDLE;
      end
      ACT_TICK: begin
        if (phase != PH_IDLE) begin
          elapsed_ticks_next = elapsed_inc;
          if (timed_out) begin
            phase_next = PH_IDLE;
          end else if (repeats) begin
            period_ticks_next = period_hit ? 16'd0 : period_inc;
          end
        end
      end
      default: begin
        case (phase)
          PH_INIT, PH_WAIT: begin
            if (rx_byte == B_SOH) begin
              phase_next = PH_RECV;
              byte_count_next = '0;
              header_ok_next = 1'b0;
              crc_running_next = CRC_INIT;
              crc_high_received_next = '0;
              elapsed_ticks_next = '0;
            end else if (rx_byte == B_CAN) begin
              phase_next = (phase == PH_INIT) ? PH_CAN_INIT : PH_CAN_WAIT;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_RECV: begin
            byte_count_next = byte_count + CW'(1);
            if (byte_count == '0) begin
              block_number_next = rx_byte;
            end else if (byte_count == CW'(1)) begin
              header_ok_next = ((block_number + rx_byte) == BLOCK_SUM);
            end else if (byte_count < N_CRC_HI) begin
              crc_running_next = crc_new;
            end else if (byte_count == N_CRC_HI) begin
              crc_high_received_next = rx_byte;
            end else begin
              frame_good_next = frame_ok;
              phase_next = PH_WAIT;
              elapsed_ticks_next = '0;
              period_ticks_next = '0;
            end
          end
          PH_CAN_INIT, PH_CAN_WAIT: begin
            phase_next = PH_IDLE;
          end
          default: ;
        endcase
      end
    endcase
  end

  always_comb begin
    qwr = '0;
    case (action)
      ACT_START: begin
        if (phase == PH_IDLE) begin
          qwr.push = 1'b1;
          qwr.entry.res.tx_valid = 1'b1;
          qwr.entry.res.tx_byte = B_REQ;
        end
      end
      ACT_STOP: begin
        if (phase != PH_IDLE) begin
          qwr.push = 1'b1;
          qwr.entry.cancel_first = 1'b1;
          qwr.entry.res.tx_valid = 1'b1;
          qwr.entry.res.tx_byte = B_CAN;
          qwr.entry.res.event_res = EV_ABORT;
        end
      end
      ACT_TICK: begin
        if (phase != PH_IDLE) begin
          if (timed_out) begin
            qwr.push = 1'b1;
            qwr.entry.cancel_first = 1'b1;
            qwr.entry.res.tx_valid = 1'b1;
            qwr.entry.res.tx_byte = B_CAN;
            qwr.entry.res.event_res = EV_ABORT;
          end else if (repeats && period_hit) begin
            qwr.push = 1'b1;
            qwr.entry.res.tx_valid = 1'b1;
            if (phase == PH_INIT) begin
              qwr.entry.res.tx_byte = B_REQ;
            end else begin
              qwr.entry.res.tx_byte = frame_good ? B_ACK : B_NAK;
            end
          end
        end
      end
      default: begin
        case (phase)
          PH_INIT, PH_WAIT: begin
            if (rx_byte == B_EOT) begin
              qwr.push = 1'b1;
              qwr.entry.res.tx_valid = 1'b1;
              qwr.entry.res.tx_byte = B_ACK;
              qwr.entry.res.event_res = EV_DONE;
            end else if (rx_byte != B_SOH && rx_byte != B_CAN) begin
              qwr.push = 1'b1;
              qwr.entry.cancel_first = 1'b1;
              qwr.entry.res.tx_valid = 1'b1;
              qwr.entry.res.tx_byte = B_CAN;
              qwr.entry.res.event_res = EV_ABORT;
            end
          end
          PH_RECV: begin
            if (byte_count >= N_HDR && byte_count < N_CRC_HI) begin
              qwr.push = 1'b1;
              qwr.entry.res.data_valid = 1'b1;
              qwr.entry.res.data_byte = rx_byte;
              qwr.entry.res.data_index = data_pos[6:0];
            end else if (byte_count > N_CRC_HI) begin
              qwr.push = 1'b1;
              qwr.entry.res.tx_valid = 1'b1;
              qwr.entry.res.tx_byte = frame_ok ? B_ACK : B_NAK;
              qwr.entry.res.event_res = frame_ok ? EV_ACCEPT : EV_REJECT;
            end
          end
          PH_CAN_INIT, PH_CAN_WAIT: begin
            qwr.push = 1'b1;
            qwr.entry.res.event_res = EV_ABORT;
            if (rx_byte != B_CAN) begin
              qwr.entry.cancel_first = 1'b1;
              qwr.entry.res.tx_valid = 1'b1;
              qwr.entry.res.tx_byte = B_CAN;
            end
          end
          default: ;
        endcase
      end
    endcase
    qwr.push = qwr.push & take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_count <= '0;
      block_number <= '0;
      header_ok <= 1'b0;
      crc_running <= CRC_INIT;
      crc_high_received <= '0;
      frame_good <= 1'b0;
      elapsed_ticks <= '0;
      period_ticks <= '0;
    end else if (take) begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      block_number <= block_number_next;
      header_ok <= header_ok_next;
      crc_running <= crc_running_next;
      crc_high_received <= crc_high_received_next;
      frame_good <= frame_good_next;
      elapsed_ticks <= elapsed_ticks_next;
      period_ticks <= period_ticks_next;
    end
  end

endmodule

// ===== src/xcr_outq.sv =====
// Two-entry result queue. An entry flagged for a leading CAN is delivered
// as two beats, the CAN first; every other entry is one beat.
// Depends on xcr_pkg.
`timescale 1ns / 1ps

module xcr_outq (
  input  logic          clk,
  input  logic          rst,
  input  xcr_pkg::qwr_t qwr,
  output logic          full,
  output logic          head_valid,
  output xcr_pkg::res_t head_res,
  output logic          head_last,
  input  logic          head_ready
);
  import xcr_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr, rd_ptr, second;
  logic [1:0] count;
  entry_t     head;
  logic       pop, beat;

  assign head = mem[rd_ptr];
  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign beat = head_valid && head_ready;
  assign pop = beat && (!head.cancel_first || second);

  always_comb begin
    head_res = head.res;
    head_last = 1'b1;
    if (head.cancel_first && !second) begin
      head_res = '0;
      head_res.tx_valid = 1'b1;
      head_res.tx_byte = B_CAN;
      head_last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (qwr.push) begin
      mem[wr_ptr] <= qwr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      second <= 1'b0;
      count <= 2'd0;
    end else begin
      if (qwr.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        second <= 1'b0;
      end else if (beat) begin
        second <= 1'b1;
      end
      case ({qwr.push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/xmodem_crc_receiver.sv =====
// Top level of the XMODEM-CRC receiver: controller and result queue.
// Depends on xcr_pkg, xcr_if, xcr_ctrl and xcr_outq.
//
//   Channel   Dir   Beat content
//   items     in    action, rx_byte
//   results   out   tx_valid, tx_byte, data_valid, data_byte, data_index,
//                   event_res, last
//   wr_*      in    register index and 16-bit value
//
// One item is accepted per cycle; its results are in the queue the next cycle.
// An abort that sends CAN CAN leaves as two result beats from one queue entry.
// Items stall while both queue entries are held, by a stalled sink or by
// aborts that each need two beats to drain.
// Reset is synchronous and puts the block idle with the default periods.
`timescale 1ns / 1ps

module xmodem_crc_receiver #(
  parameter int PAYLOAD_BYTES = xcr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  xcr_item_if.sink    items,
  xcr_result_if.source results,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);
  import xcr_pkg::*;

  qwr_t qwr;
  res_t head_res;
  logic full, take, idle;

  assign items.ready = !full;
  assign take = items.valid && items.ready;

  xcr_ctrl #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .action   (items.action),
    .rx_byte  (items.rx_byte),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .qwr      (qwr),
    .idle     (idle)
  );

  xcr_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .qwr        (qwr),
    .full       (full),
    .head_valid (results.valid),
    .head_res   (head_res),
    .head_last  (results.last),
    .head_ready (results.ready)
  );

  assign results.tx_valid = head_res.tx_valid;
  assign results.tx_byte = head_res.tx_byte;
  assign results.data_valid = head_res.data_valid;
  assign results.data_byte = head_res.data_byte;
  assign results.data_index = head_res.data_index;
  assign results.event_res = head_res.event_res;

  a_prefix_is_can: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.last |-> results.tx_valid && results.tx_byte == B_CAN)
    else $error("non-final beat is not a CAN");

  a_stop_answers: assert property (@(posedge clk) disable iff (rst)
    take && items.action == ACT_STOP && !idle |=> results.valid && idle)
    else $error("stop while busy gave no result or left the block busy");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.tx_valid && results.data_valid))
    else $error("result carries both a tx byte and a data byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !results.valid && idle)
    else $error("results pending after reset");

endmodule
